FILE: sv/rbrc_pkg.sv
// Shared types, codes and helper functions for the recent block range cache.
// Used by the cell, the top level and the port checker; depends on nothing.
package rbrc_pkg;

  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 32;
  localparam int CFG_W         = 7;
  localparam int DEFAULT_DEPTH = 64;
  localparam int RESET_ENTRIES = 32;

  localparam logic [ADDR_W-1:0] LOW_HEAP_LIMIT = ADDR_W'(32'h100);

  // Command codes.
  localparam logic [2:0] OP_LOOKUP     = 3'd0;
  localparam logic [2:0] OP_ALLOC      = 3'd1;
  localparam logic [2:0] OP_BLOCK      = 3'd2;
  localparam logic [2:0] OP_NON_HEAP   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;
  localparam logic [2:0] OP_HEAP_CHECK = 3'd5;

  // Result status codes.
  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_BLOCK   = 2'd1;
  localparam logic [1:0] STATUS_NONHEAP = 2'd2;

  // What stopped the search at an entry.
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_NONHEAP = 2'd2;
  localparam logic [1:0] KIND_BLOCK   = 2'd3;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } token_t;

  // Write and clear commands broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              clr;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } wr_t;

  // An address lies inside the heap marks unless it is above a set high mark
  // or below the low mark.
  function automatic logic in_marks(input logic [ADDR_W-1:0] a,
                                    input logic [ADDR_W-1:0] lo,
                                    input logic [ADDR_W-1:0] hi);
    logic above;
    above = (hi != '0) && (a > hi);
    return !above && (a >= lo);
  endfunction

  // Smallest power of two not below v, for v of one or more.
  function automatic logic [7:0] round_pow2(input logic [CFG_W-1:0] v);
    logic [7:0] p;
    p = 8'd1;
    for (int j = 0; j < 8; j++) begin
      if (p < {1'b0, v}) begin
        p = p << 1;
      end
    end
    return p;
  endfunction

endpackage

FILE: sv/rbrc_cell.sv
// One ring entry of the range cache with its stage of the search chain.
// Depends on rbrc_pkg for the token and write word types.
module rbrc_cell #(
  parameter int DEPTH = 64,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(DEPTH)-1:0]     slot,
  input  logic [$clog2(DEPTH+1)-1:0]   n,
  input  rbrc_pkg::wr_t                wr,
  input  logic [rbrc_pkg::ADDR_W-1:0]  addr,
  input  rbrc_pkg::token_t             tok_in,
  input  logic [$clog2(DEPTH)-1:0]     age_in,
  output rbrc_pkg::token_t             tok_out,
  output logic [$clog2(DEPTH)-1:0]     age_out
);
  import rbrc_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int CW = NW + 1;
  localparam logic [IW-1:0] IDX_I = IW'(INDEX);
  localparam logic [NW-1:0] IDX_N = NW'(INDEX);
  localparam logic [CW-1:0] IDX_C = CW'(INDEX);

  logic [ADDR_W-1:0] base;
  logic [SIZE_W-1:0] size;
  logic              in_ring;
  logic              is_slot;
  logic [CW-1:0]     age_raw;
  logic [CW-1:0]     age_wrap;
  logic [IW-1:0]     age;
  logic [ADDR_W-1:0] offset;
  logic [1:0]        kind;
  logic              take;

  // The cell belongs to the ring when its index is below the ring size; the
  // slot the next write goes to holds the oldest entry and is never searched.
  assign in_ring = IDX_N < n;
  assign is_slot = slot == IDX_I;

  // Age of this entry counted back from the newest one, modulo the ring size.
  always_comb begin
    age_raw = CW'(slot) + CW'(n) - CW'(1) - IDX_C;
    if (age_raw >= CW'(n)) begin
      age_wrap = age_raw - CW'(n);
    end else begin
      age_wrap = age_raw;
    end
    age = IW'(age_wrap);
  end

  // Classify what this entry does to the search.
  always_comb begin
    offset = addr - base;
    if (base == '0) begin
      kind = KIND_EMPTY;
    end else if (size == '0) begin
      kind = (base == addr) ? KIND_NONHEAP : KIND_NONE;
    end else begin
      kind = (offset < ADDR_W'(size)) ? KIND_BLOCK : KIND_NONE;
    end
  end

  // The younger of the stop already carried and this one wins.
  assign take = tok_in.valid && in_ring && !is_slot && (kind != KIND_NONE) &&
                (age < age_in);

  // Hand the token on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (take) begin
      tok_out.kind <= kind;
      tok_out.base <= base;
      tok_out.size <= size;
      age_out      <= age;
    end else begin
      tok_out.kind <= tok_in.kind;
      tok_out.base <= tok_in.base;
      tok_out.size <= tok_in.size;
      age_out      <= age_in;
    end
  end

  // Entry storage: a zero base marks the entry as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (wr.en && is_slot) begin
      base <= wr.base;
    end else if (wr.clr && in_ring) begin
      base <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && is_slot) begin
      size <= wr.size;
    end
  end

endmodule

FILE: sv/recent_block_range_cache.sv
// A lookup settled without the ring, and any other command, gives its result
// in the cycle after start is taken; a ring search passes the launch register,
// the DEPTH cells and the output register, with busy high until the cycle of
// the result. Throughput: one command per cycle except during a ring search,
// which lasts while the token walks the DEPTH cells one cell per cycle.
// Reset (rst, synchronous) empties every entry, clears marks and write slot,
// and sets the ring size to 32 capped at DEPTH; results cannot be stalled.
module recent_block_range_cache #(
  parameter int DEPTH = rbrc_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    opcode,
  input  logic [rbrc_pkg::ADDR_W-1:0]   address,
  input  logic [rbrc_pkg::SIZE_W-1:0]   block_size,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [rbrc_pkg::ADDR_W-1:0]   found_base,
  output logic [rbrc_pkg::SIZE_W-1:0]   found_size,
  output logic                          in_heap,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbrc_pkg::CFG_W-1:0]    cfg_data
);
  import rbrc_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
  localparam logic [NW-1:0] RESET_N =
    NW'((RESET_ENTRIES > DEPTH) ? DEPTH : RESET_ENTRIES);

  // Control and mark registers.
  logic [NW-1:0]     n;
  logic [NW-1:0]     n_next;
  logic [IW-1:0]     write_slot;
  logic [ADDR_W-1:0] heap_low;
  logic [ADDR_W-1:0] heap_high;
  logic [ADDR_W-1:0] look_addr;
  logic              inj_valid;

  logic              accept;
  logic              a_inside;
  logic              walk_go;
  logic              is_record;
  logic [IW-1:0]     slot_eff;
  logic [NW-1:0]     slot_inc;
  logic [IW-1:0]     slot_adv;
  logic [ADDR_W:0]   high_sum;
  logic [7:0]        cfg_pow;
  wr_t               wr;

  logic              done_next;
  logic [1:0]        status_next;
  logic [ADDR_W-1:0] base_next;
  logic [SIZE_W-1:0] size_next;
  logic              in_heap_next;

  token_t            tok [DEPTH+1];
  logic [IW-1:0]     age [DEPTH+1];

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign a_inside  = in_marks(address, heap_low, heap_high);
  assign walk_go   = accept && (opcode == OP_LOOKUP) && (n != '0) && a_inside;
  assign is_record = (opcode == OP_ALLOC) || (opcode == OP_BLOCK) ||
                     (opcode == OP_NON_HEAP);

  // The write slot is reduced into the ring when the ring has shrunk; a
  // smaller ring is always a power of two, so a mask does it.
  always_comb begin
    if (NW'(write_slot) >= n) begin
      slot_eff = write_slot & IW'(n - NW'(1));
    end else begin
      slot_eff = write_slot;
    end
    slot_inc = NW'(slot_eff) + NW'(1);
    slot_adv = (slot_inc == n) ? '0 : IW'(slot_inc);
  end

  // Write and clear words for the cells.
  always_comb begin
    wr.en   = accept && is_record && (n != '0);
    wr.clr  = accept && (opcode == OP_CLEAR);
    wr.base = address;
    wr.size = (opcode == OP_NON_HEAP) ? '0 : block_size;
  end

  // Ring size register: zero, or rounded up to a power of two, capped at DEPTH.
  always_comb begin
    cfg_pow = round_pow2(cfg_data);
    if (cfg_data == '0) begin
      n_next = '0;
    end else if (32'(cfg_pow) > DEPTH) begin
      n_next = DEPTH_N;
    end else begin
      n_next = NW'(cfg_pow);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= RESET_N;
    end else if (cfg_valid && cfg_ready) begin
      n <= n_next;
    end
  end

  // Write slot and heap marks.
  assign high_sum = {1'b0, address} + {1'b0, block_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      heap_low   <= '0;
      heap_high  <= '0;
    end else if (accept) begin
      if (opcode == OP_CLEAR) begin
        write_slot <= '0;
      end else if (wr.en) begin
        write_slot <= slot_adv;
      end
      if (opcode == OP_ALLOC) begin
        if ((heap_low == '0) || (address < heap_low)) begin
          heap_low <= address;
        end
        if (address > heap_high) begin
          heap_high <= high_sum[ADDR_W] ? '1 : high_sum[ADDR_W-1:0];
        end
      end
    end
  end

  // Search launch: the address is held while the token walks the chain.
  always_ff @(posedge clk) begin
    if (walk_go) begin
      look_addr <= address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inj_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      inj_valid <= walk_go;
      if (walk_go) begin
        busy <= 1'b1;
      end else if (tok[0].valid) begin
        busy <= 1'b0;
      end
    end
  end

  // The token enters at the top cell and leaves at cell zero.
  assign tok[DEPTH] = {inj_valid, KIND_NONE, {ADDR_W{1'b0}}, {SIZE_W{1'b0}}};
  assign age[DEPTH] = '1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rbrc_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .slot    (slot_eff),
      .n       (n),
      .wr      (wr),
      .addr    (look_addr),
      .tok_in  (tok[i+1]),
      .age_in  (age[i+1]),
      .tok_out (tok[i]),
      .age_out (age[i])
    );
  end

  // Result word: immediate commands, or the token leaving the chain.
  always_comb begin
    done_next    = (accept && !walk_go) || tok[0].valid;
    status_next  = STATUS_NONE;
    base_next    = '0;
    size_next    = '0;
    in_heap_next = 1'b0;
    if (tok[0].valid) begin
      if (tok[0].kind == KIND_NONHEAP) begin
        status_next = STATUS_NONHEAP;
      end else if ((tok[0].kind == KIND_BLOCK) &&
                   in_marks(tok[0].base, heap_low, heap_high)) begin
        status_next = STATUS_BLOCK;
        base_next   = tok[0].base;
        size_next   = tok[0].size;
      end
    end else if (accept) begin
      case (opcode)
        OP_LOOKUP: begin
          if ((n != '0) && !a_inside) begin
            status_next = STATUS_NONHEAP;
          end
        end
        OP_HEAP_CHECK: begin
          if (heap_high != '0) begin
            in_heap_next = a_inside;
          end else begin
            in_heap_next = address > LOW_HEAP_LIMIT;
          end
        end
        default: begin
          status_next = STATUS_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status     <= status_next;
    found_base <= base_next;
    found_size <= size_next;
    in_heap    <= in_heap_next;
  end

endmodule

FILE: sv/rbrc_checker.sv
// Port-level checks for the recent block range cache, bound to the top level.
// Depends on rbrc_pkg for command and status codes.
module rbrc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [2:0]                  opcode,
  input logic                        done,
  input logic [1:0]                  status,
  input logic [rbrc_pkg::ADDR_W-1:0] found_base,
  input logic [rbrc_pkg::SIZE_W-1:0] found_size,
  input logic                        in_heap
);
  import rbrc_pkg::*;

  // A result word only follows a taken command or a search in progress.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a command");

  // Any command other than a lookup answers in the next cycle.
  a_quick_commands: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode != OP_LOOKUP)) |=> done)
    else $error("non-lookup command gave no result word");

  // A search only begins when a command is taken.
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // Base and size are shown only with a found heap block.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STATUS_BLOCK)) |-> ((found_base == '0) && (found_size == '0)))
    else $error("found fields set without a heap block");

  // A heap check never reports a lookup status.
  a_heap_check_alone: assert property (@(posedge clk) disable iff (rst)
    (done && in_heap) |-> (status == STATUS_NONE))
    else $error("heap check and lookup status both set");

endmodule

bind recent_block_range_cache rbrc_checker u_rbrc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .opcode     (opcode),
  .done       (done),
  .status     (status),
  .found_base (found_base),
  .found_size (found_size),
  .in_heap    (in_heap)
);

FILE: dv/tb_recent_block_range_cache.sv
// Self-checking testbench for the recent block range cache: a directed table,
// then random phases at several ring sizes, checked against a predictor or fixed rows.
// Depends on rbrc_pkg and recent_block_range_cache only.
module tb_recent_block_range_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import rbrc_pkg::*;

  localparam int RING_DEPTH = DEFAULT_DEPTH;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [31:0] HEAP_REGION = 32'h1000_0000;
  localparam int PHASE_WORDS = 94;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] base;
    logic [31:0] len;
    logic        in_heap;
  } lookup_result_t;

  typedef struct packed {
    logic [2:0]     op;
    logic [31:0]    addr;
    logic [31:0]    len;
    logic           fixed;
    lookup_result_t want;
  } stim_row_t;

  localparam lookup_result_t QUIET     = '{STATUS_NONE, 32'h0, 32'h0, 1'b0};
  localparam lookup_result_t HEAP_YES  = '{STATUS_NONE, 32'h0, 32'h0, 1'b1};
  localparam lookup_result_t OUTSIDE   = '{STATUS_NONHEAP, 32'h0, 32'h0, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = OP_LOOKUP;
  logic [31:0] address = '0;
  logic [31:0] block_size = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] found_base;
  logic [31:0] found_size;
  logic        in_heap;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  // Predictor state: a copy of the ring, its slot pointer, marks and ring size.
  logic [31:0] ent_base [RING_DEPTH];
  logic [31:0] ent_len  [RING_DEPTH];
  int unsigned ring_len;
  int unsigned next_slot;
  logic [31:0] mark_low;
  logic [31:0] mark_high;

  lookup_result_t pending_results[$];
  logic [31:0]    seen_base[$];
  logic [31:0]    seen_len[$];
  stim_row_t      directed_rows [26];
  int             mismatches = 0;
  bit             gaps_allowed = 1'b1;

  recent_block_range_cache dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .address    (address),
    .block_size (block_size),
    .done       (done),
    .status     (status),
    .found_base (found_base),
    .found_size (found_size),
    .in_heap    (in_heap),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("** recent_block_range_cache: FAILED **");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // An address sits inside the heap unless above a set high mark or below the low one.
  function automatic bit within_marks(input logic [31:0] a);
    if (mark_high != 0 && a > mark_high) begin
      return 1'b0;
    end
    return a >= mark_low;
  endfunction

  function automatic void store_entry(input logic [31:0] base, input logic [31:0] len);
    int unsigned slot;
    if (ring_len == 0) begin
      return;
    end
    slot = next_slot % ring_len;
    ent_base[slot] = base;
    ent_len[slot] = len;
    next_slot = (slot + 1) % ring_len;
  endfunction

  function automatic void set_ring_len(input logic [6:0] v);
    int unsigned p;
    p = 1;
    if (v == 0) begin
      ring_len = 0;
    end else begin
      while (p < v) p = p << 1;
      ring_len = (p > RING_DEPTH) ? RING_DEPTH : p;
    end
  endfunction

  // Applies one command word to the predicted cache and returns its result.
  function automatic lookup_result_t cache_step(input logic [2:0] op,
                                                input logic [31:0] a,
                                                input logic [31:0] len);
    lookup_result_t r;
    int unsigned idx;
    logic [31:0] b;
    logic [32:0] top;
    r = QUIET;
    case (op)
      OP_LOOKUP: begin
        if (ring_len != 0) begin
          if (!within_marks(a)) begin
            r.status = STATUS_NONHEAP;
          end else begin
            idx = next_slot % ring_len;
            for (int unsigned k = 1; k < ring_len; k++) begin
              idx = (idx + ring_len - 1) % ring_len;
              b = ent_base[idx];
              if (b == 0) break;
              if (ent_len[idx] == 0) begin
                if (b == a) begin
                  r.status = STATUS_NONHEAP;
                  break;
                end
              end else if (32'(a - b) < ent_len[idx]) begin
                if (within_marks(b)) begin
                  r.status = STATUS_BLOCK;
                  r.base = b;
                  r.len = ent_len[idx];
                end
                break;
              end
            end
          end
        end
      end
      OP_ALLOC: begin
        if (mark_low == 0 || a < mark_low) begin
          mark_low = a;
        end
        if (a > mark_high) begin
          top = {1'b0, a} + {1'b0, len};
          mark_high = top[32] ? '1 : top[31:0];
        end
        store_entry(a, len);
      end
      OP_BLOCK: store_entry(a, len);
      OP_NON_HEAP: store_entry(a, 32'h0);
      OP_CLEAR: begin
        for (int unsigned i = 0; i < ring_len; i++) begin
          ent_base[i] = '0;
          ent_len[i] = '0;
        end
        next_slot = 0;
      end
      OP_HEAP_CHECK: begin
        r.in_heap = (mark_high != 0) ? within_marks(a) : (a > LOW_HEAP_LIMIT);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Presents one command word, waits for it to be taken and records its outcome.
  task automatic issue_word(input logic [2:0] op, input logic [31:0] a,
                            input logic [31:0] len, input logic fixed,
                            input lookup_result_t want);
    lookup_result_t predicted;
    if (gaps_allowed && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    address <= a;
    block_size <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = cache_step(op, a, len);
    pending_results.push_back(fixed ? want : predicted);
    if (op == OP_ALLOC || op == OP_BLOCK || op == OP_NON_HEAP) begin
      seen_base.push_back(a);
      seen_len.push_back(op == OP_NON_HEAP ? 32'h0 : len);
      if (seen_base.size() > 32) begin
        void'(seen_base.pop_front());
        void'(seen_len.pop_front());
      end
    end
  endtask

  // Holds the sender off until every outstanding word has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random word: mostly records in a heap region and lookups close to recent
  // records, with some clears, heap checks and fully random noise.
  task automatic issue_random_word(input bit wild_allocs);
    int pick;
    int j;
    logic [2:0] op;
    logic [31:0] a;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    a = HEAP_REGION | ($urandom & 32'h00FF_FFF8);
    len = $urandom_range(1, 4096);
    op = OP_LOOKUP;
    if (pick < 32 && seen_base.size() != 0) begin
      j = $urandom_range(0, seen_base.size() - 1);
      a = seen_base[j] + $urandom_range(0, seen_len[j] + 8);
    end else if (pick < 50) begin
      op = OP_ALLOC;
      if ($urandom_range(0, 19) == 0) len = '0;
    end else if (pick < 62) begin
      op = OP_BLOCK;
      // A block based below the low mark but reaching into the heap.
      if ($urandom_range(0, 3) == 0) begin
        a = $urandom_range(32'h100, 32'h1FFF);
        len = 32'h4000;
      end
    end else if (pick < 70) begin
      op = OP_NON_HEAP;
      if ($urandom_range(0, 1) == 0) a = $urandom;
    end else if (pick < 72) begin
      op = OP_CLEAR;
    end else if (pick < 80) begin
      op = OP_HEAP_CHECK;
      a = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3000);
    end else if (pick < 90) begin
      a = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3000);
    end else begin
      op = 3'($urandom_range(0, 7));
      a = $urandom;
      len = $urandom;
      if (op == OP_ALLOC && !wild_allocs) op = OP_BLOCK;
    end
    issue_word(op, a, len, 1'b0, QUIET);
  endtask

  // Result checker: each strobed word is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    lookup_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing outstanding", 32'(status), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) note_mismatch("status", 32'(status), 32'(want.status));
        if (found_base !== want.base) note_mismatch("found_base", found_base, want.base);
        if (found_size !== want.len) note_mismatch("found_size", found_size, want.len);
        if (in_heap !== want.in_heap) note_mismatch("in_heap", 32'(in_heap), 32'(want.in_heap));
      end
    end
  end

  initial begin : stimulus
    int unsigned ring_settings [8];
    ring_settings = '{64, 1, 0, 3, 127, 16, 2, 32};

    // Directed table; rows with fixed set carry their result, the rest are predicted.
    directed_rows = '{
      '{OP_LOOKUP,     32'h0000_1000, 32'h0,         1'b1, QUIET},
      '{OP_HEAP_CHECK, 32'h0000_0100, 32'h0,         1'b1, QUIET},
      '{OP_HEAP_CHECK, 32'h0000_0101, 32'h0,         1'b1, HEAP_YES},
      '{OP_SPARE_LO,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, QUIET},
      '{OP_SPARE_HI,   32'h0,         32'h0,         1'b1, QUIET},
      '{OP_ALLOC,      32'h0000_1000, 32'h100,       1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_1080, 32'h0,         1'b0, QUIET},
      '{OP_LOOKUP,     32'h0000_0FFF, 32'h0,         1'b1, OUTSIDE},
      '{OP_LOOKUP,     32'h0000_1101, 32'h0,         1'b1, OUTSIDE},
      '{OP_NON_HEAP,   32'h0000_1050, 32'h0,         1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_1050, 32'h0,         1'b0, QUIET},
      '{OP_BLOCK,      32'h0000_1040, 32'h20,        1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_1044, 32'h0,         1'b0, QUIET},
      '{OP_BLOCK,      32'h0000_0F00, 32'h200,       1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_1010, 32'h0,         1'b0, QUIET},
      '{OP_ALLOC,      32'h0,         32'h0,         1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_1044, 32'h0,         1'b0, QUIET},
      '{OP_ALLOC,      32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, QUIET},
      '{OP_LOOKUP,     32'hFFFF_FFFF, 32'h0,         1'b0, QUIET},
      '{OP_HEAP_CHECK, 32'hFFFF_FFFF, 32'h0,         1'b0, QUIET},
      '{OP_ALLOC,      32'h0000_2000, 32'h0,         1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_2000, 32'h0,         1'b0, QUIET},
      '{OP_BLOCK,      32'hFFFF_FFF0, 32'h2020,      1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_2005, 32'h0,         1'b0, QUIET},
      '{OP_CLEAR,      32'h0,         32'h0,         1'b1, QUIET},
      '{OP_LOOKUP,     32'h0000_1044, 32'h0,         1'b0, QUIET}
    };

    // Predicted state after reset.
    for (int i = 0; i < RING_DEPTH; i++) begin
      ent_base[i] = '0;
      ent_len[i] = '0;
    end
    next_slot = 0;
    mark_low = '0;
    mark_high = '0;
    ring_len = (RESET_ENTRIES > RING_DEPTH) ? RING_DEPTH : RESET_ENTRIES;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_word(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].len,
                 directed_rows[i].fixed, directed_rows[i].want);
    end

    // Random phases, each at its own ring size, written while the block is idle.
    foreach (ring_settings[p]) begin
      drain_results();
      cfg_valid <= 1'b1;
      cfg_data <= 7'(ring_settings[p]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      set_ring_len(7'(ring_settings[p]));
      gaps_allowed = (p != 4);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        issue_random_word(p == 7);
      end
    end

    // Wait for the tail, then allow stray results time to show.
    drain_results();
    repeat (RING_DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch("results never produced", pending_results.size(), 32'h0);
    end
    if (mismatches == 0) begin
      $display("** recent_block_range_cache: PASSED **");
    end else begin
      $display("** recent_block_range_cache: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rbrc_pkg.sv
sv/rbrc_cell.sv
sv/recent_block_range_cache.sv
sv/rbrc_checker.sv
dv/tb_recent_block_range_cache.sv
